// File: rtl/tmta_pkg.sv
`timescale 1ns / 1ps

package tmta_pkg;

   typedef enum logic {
      CMD_BYTE  = 1'b0,
      CMD_COLOR = 1'b1
   } cmd_kind_type;

   typedef enum logic [1:0] {
      TGT_NONE = 2'd0,
      TGT_FG   = 2'd1,
      TGT_BG   = 2'd2
   } target_type;

   // data holds the raw byte, or {bg, digit} in the low five bits for a color
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   localparam int QueueDepth = 2;
   localparam int ColorLen   = 6;

   localparam logic [7:0] ChEsc    = 8'h1B;
   localparam logic [7:0] ChBrack  = 8'h5B;
   localparam logic [7:0] ChM      = 8'h6D;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChN      = 8'h6E;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChBang   = 8'h21;
   localparam logic [7:0] ChStar   = 8'h2A;
   localparam logic [7:0] ChX      = 8'h78;
   localparam logic [7:0] ChZero   = 8'h30;

   // sgr codes as three bcd digits, foreground first then background
   localparam logic [11:0] ColorBcd [32] = '{
      12'h030, 12'h034, 12'h032, 12'h036, 12'h031, 12'h035, 12'h033, 12'h090,
      12'h037, 12'h094, 12'h092, 12'h096, 12'h091, 12'h095, 12'h093, 12'h097,
      12'h040, 12'h044, 12'h042, 12'h046, 12'h041, 12'h045, 12'h043, 12'h100,
      12'h047, 12'h104, 12'h102, 12'h106, 12'h101, 12'h105, 12'h103, 12'h107
   };

   // bit 4 set means not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

// File: rtl/tty_markup_to_ansi_filter.sv
`timescale 1ns / 1ps
// channel   valid       stall       payload
// input     req_valid   req_stall   req_in_byte
// result    rsp_valid   rsp_stall   rsp_out_byte, rsp_last
//
// one input byte per cycle unless stalled; a plain or raw byte passes the queue, then output register
// a color escape sends five or six bytes, one per cycle unless stalled, from the back end
// a two-entry queue parts the parser from the emitter; input stalls only when it is full
// reset clears parser state, queue pointers and output valid

module tty_markup_to_ansi_filter import tmta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic    q_full;
   logic    q_push;
   cmd_type q_cmd;
   logic    q_pop;
   logic    head_valid;
   cmd_type head_cmd;

   tmta_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   tmta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tmta_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// File: rtl/tmta_front.sv
`timescale 1ns / 1ps

module tmta_front import tmta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   logic       esc_ff, esc_in;
   logic       dollar_ff, dollar_in;
   target_type target_ff, target_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] accum_ff, accum_in;
   logic       emit;
   logic       accept;
   logic [4:0] hex_d;
   logic [7:0] nib;
   logic [7:0] acc_new;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept && emit;
   assign hex_d     = hex_value(req_in_byte);
   assign nib       = hex_d[4] ? 8'hFF : {4'h0, hex_d[3:0]};
   assign acc_new   = {accum_ff[3:0], 4'h0} | nib;

   always_comb begin
      esc_in    = esc_ff;
      dollar_in = dollar_ff;
      target_in = target_ff;
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      emit      = 1'b0;
      q_cmd     = '{kind: CMD_BYTE, data: req_in_byte};
      priority if (esc_ff) begin
         esc_in = 1'b0;
         if (req_in_byte == ChBslash || req_in_byte == ChDollar) begin
            emit = 1'b1;
         end else if (req_in_byte == ChN) begin
            emit       = 1'b1;
            q_cmd.data = ChLf;
         end
      end else if (dollar_ff) begin
         priority if (req_in_byte == ChBang) begin
            target_in = TGT_FG;
         end else if (req_in_byte == ChStar) begin
            target_in = TGT_BG;
         end else if (req_in_byte == ChX) begin
            phase_in = 2'd1;
         end else if (phase_ff != 2'd0) begin
            if (phase_ff == 2'd2) begin
               emit       = 1'b1;
               q_cmd.data = acc_new;
               accum_in   = 8'h00;
               dollar_in  = 1'b0;
               phase_in   = 2'd0;
            end else begin
               accum_in = acc_new;
               phase_in = 2'd2;
            end
         end else begin
            if (!hex_d[4] && target_ff != TGT_NONE) begin
               emit  = 1'b1;
               q_cmd = '{kind: CMD_COLOR,
                         data: {3'b000, target_ff == TGT_BG, hex_d[3:0]}};
            end
            target_in = TGT_NONE;
            dollar_in = 1'b0;
         end
      end else if (req_in_byte[7]) begin
         emit = 1'b1;
      end else if (req_in_byte == ChBslash) begin
         esc_in = 1'b1;
      end else if (req_in_byte == ChDollar) begin
         dollar_in = 1'b1;
      end else begin
         emit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff    <= 1'b0;
         dollar_ff <= 1'b0;
         target_ff <= TGT_NONE;
         phase_ff  <= 2'd0;
         accum_ff  <= 8'h00;
      end else if (accept) begin
         esc_ff    <= esc_in;
         dollar_ff <= dollar_in;
         target_ff <= target_in;
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
      end
   end

endmodule

// File: rtl/tmta_queue.sv
`timescale 1ns / 1ps

module tmta_queue import tmta_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PtrW = $clog2(QueueDepth);

   cmd_type                    mem [QueueDepth];
   logic [PtrW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [$clog2(QueueDepth+1)-1:0] count_ff, count_in;

   assign full       = (count_ff == QueueDepth[$clog2(QueueDepth+1)-1:0]);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/tmta_back.sv
`timescale 1ns / 1ps

module tmta_back import tmta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   localparam int PosW = $clog2(ColorLen);

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      byte_ff, byte_in;
   logic            last_ff, last_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic            out_load;
   logic [11:0]     bcd;
   logic            hund;
   logic [PosW-1:0] slot;
   logic            is_last;

   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign bcd      = ColorBcd[head_cmd.data[4:0]];
   assign hund     = (bcd[11:8] != 4'h0);
   assign slot     = (!hund && pos_ff >= PosW'(2)) ? pos_ff + 1'b1 : pos_ff;

   always_comb begin
      if (head_cmd.kind == CMD_BYTE) begin
         is_last = 1'b1;
      end else begin
         is_last = (slot == PosW'(ColorLen - 1));
      end
   end

   always_comb begin
      byte_in = ChM;
      if (head_cmd.kind == CMD_BYTE) begin
         byte_in = head_cmd.data;
      end else begin
         unique case (slot)
            PosW'(0): byte_in = ChEsc;
            PosW'(1): byte_in = ChBrack;
            PosW'(2): byte_in = ChZero | {4'h0, bcd[11:8]};
            PosW'(3): byte_in = ChZero | {4'h0, bcd[7:4]};
            PosW'(4): byte_in = ChZero | {4'h0, bcd[3:0]};
            default:  byte_in = ChM;
         endcase
      end
   end

   assign pop          = out_load && head_valid && is_last;
   assign last_in      = is_last;
   assign rsp_valid_in = out_load ? head_valid : rsp_valid_ff;
   assign pos_in       = (out_load && head_valid) ? (is_last ? '0 : pos_ff + 1'b1) : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && head_valid) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

// File: tb/tty_markup_to_ansi_filter_tb.sv
`timescale 1ns / 1ps

module tty_markup_to_ansi_filter_tb;
   import tmta_pkg::*;

   localparam int RandomItems = 440;
   localparam int CalmTail    = 400;
   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 24;
   localparam int ReportLimit = 10;

   localparam int FgSgr [16] = '{
      30, 34, 32, 36, 31, 35, 33, 90, 37, 94, 92, 96, 91, 95, 93, 97
   };

   // backslash pairs, high and low bytes, colors, raw hex bytes and their odd cases
   localparam int OpeningLen = 30;
   localparam logic [7:0] OpeningBytes [OpeningLen] = '{
      8'h00, 8'hFF,
      ChBslash, ChBslash, ChBslash, ChN, ChBslash, ChDollar, ChBslash, 8'h71,
      ChDollar, ChStar, 8'h37,
      ChDollar, 8'h35,
      ChDollar, ChStar, 8'h90,
      ChDollar, ChX, 8'h34, ChX, ChBang, 8'h31,
      ChDollar, 8'h61,
      ChDollar, ChX, 8'h7A, 8'h33
   };

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } term_byte_type;

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
      return -1;
   endfunction

   class markup_tracker;
      bit            escaping;
      bit            in_command;
      target_type    color_sel = TGT_NONE;
      logic [1:0]    hex_phase = 2'd0;
      logic [7:0]    hex_accum = 8'h00;
      term_byte_type pending_term_bytes [$];
      int            mismatches;

      function void accept_char(input logic [7:0] c);
         logic [7:0] burst [$];
         int nib;
         int code;
         if (escaping) begin
            if (c == ChBslash) burst.push_back(ChBslash);
            else if (c == ChN) burst.push_back(ChLf);
            else if (c == ChDollar) burst.push_back(ChDollar);
            escaping = 0;
         end else if (in_command) begin
            if (c == ChBang) begin
               color_sel = TGT_FG;
            end else if (c == ChStar) begin
               color_sel = TGT_BG;
            end else if (c == ChX) begin
               hex_phase = 2'd1;
            end else if (hex_phase != 2'd0) begin
               nib = nibble_of(c);
               hex_accum = {hex_accum[3:0], 4'h0} | ((nib < 0) ? 8'hFF : 8'(nib));
               hex_phase = hex_phase + 2'd1;
               if (hex_phase == 2'd3) begin
                  burst.push_back(hex_accum);
                  hex_accum = 8'h00;
                  hex_phase = 2'd0;
                  in_command = 0;
               end
            end else begin
               nib = nibble_of(c);
               if (nib >= 0 && color_sel != TGT_NONE) begin
                  code = FgSgr[nib] + ((color_sel == TGT_BG) ? 10 : 0);
                  burst.push_back(ChEsc);
                  burst.push_back(ChBrack);
                  if (code >= 100) burst.push_back(ChZero + 8'(code / 100));
                  burst.push_back(ChZero + 8'((code / 10) % 10));
                  burst.push_back(ChZero + 8'(code % 10));
                  burst.push_back(ChM);
               end
               color_sel = TGT_NONE;
               in_command = 0;
            end
         end else if (c[7]) begin
            burst.push_back(c);
         end else if (c == ChBslash) begin
            escaping = 1;
         end else if (c == ChDollar) begin
            in_command = 1;
         end else begin
            burst.push_back(c);
         end
         foreach (burst[i]) pending_term_bytes.push_back({burst[i], i == burst.size() - 1});
      endfunction

      function void note_fault(input logic [7:0] want_value, input logic want_last,
                               input logic [7:0] got_value, input logic got_last,
                               input bit unexpected);
         mismatches++;
         if (mismatches <= ReportLimit) begin
            if (unexpected)
               $display("mismatch: unexpected output byte %02h last %0b", got_value, got_last);
            else
               $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                        want_value, want_last, got_value, got_last);
         end
      endfunction

      function void check_term_byte(input logic [7:0] got_value, input logic got_last);
         term_byte_type want;
         if (pending_term_bytes.size() == 0) begin
            note_fault(8'h00, 1'b0, got_value, got_last, 1);
         end else begin
            want = pending_term_bytes.pop_front();
            if (want.value !== got_value || want.last !== got_last)
               note_fault(want.value, want.last, got_value, got_last, 0);
         end
      endfunction

      function int outstanding();
         return pending_term_bytes.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   markup_tracker tracker = new;
   string hex_digits = "0123456789abcdefABCDEF";
   int    chars_sent;
   int    cycle_count;
   int    stall_left;
   bit    calm_tail;

   tty_markup_to_ansi_filter uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end else if (!calm_tail && !reset && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 14);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_term_byte(rsp_out_byte, rsp_last);
   end

   task automatic send_char(input logic [7:0] c);
      if (!calm_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= c;
      do @(posedge clock); while (req_stall);
      tracker.accept_char(c);
      chars_sent++;
      if (chars_sent >= CalmTail) calm_tail = 1;
   endtask

   function automatic logic [7:0] pick_digit();
      if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
      return hex_digits[$urandom_range(0, 21)];
   endfunction

   function automatic logic [7:0] pick_target();
      return $urandom_range(0, 1) ? ChBang : ChStar;
   endfunction

   task automatic send_random_phrase();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: begin
            send_char(8'($urandom_range(32, 126)));
         end
         3: begin
            send_char(ChBslash);
            case ($urandom_range(0, 3))
               0: send_char(ChBslash);
               1: send_char(ChN);
               2: send_char(ChDollar);
               default: send_char(8'($urandom_range(0, 255)));
            endcase
         end
         4, 5: begin
            send_char(ChDollar);
            if ($urandom_range(0, 4) != 0) send_char(pick_target());
            if ($urandom_range(0, 5) == 0) send_char(pick_target());
            send_char(pick_digit());
         end
         6, 7: begin
            send_char(ChDollar);
            if ($urandom_range(0, 3) == 0) send_char(pick_target());
            send_char(ChX);
            send_char(pick_digit());
            if ($urandom_range(0, 5) == 0) begin
               case ($urandom_range(0, 2))
                  0: send_char(ChBang);
                  1: send_char(ChStar);
                  default: send_char(ChX);
               endcase
            end
            send_char(pick_digit());
         end
         8: begin
            send_char(ChDollar);
            send_char(8'($urandom_range(128, 255)));
         end
         default: begin
            send_char(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (OpeningBytes[i]) send_char(OpeningBytes[i]);
      while (chars_sent < OpeningLen + RandomItems) send_random_phrase();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
rtl/tmta_pkg.sv
rtl/tmta_front.sv
rtl/tmta_queue.sv
rtl/tmta_back.sv
rtl/tty_markup_to_ansi_filter.sv
tb/tty_markup_to_ansi_filter_tb.sv
